// ----- hdl/nfopll_pkg.sv -----
// Shared types, constants and helper functions for the flux observer with PLL.
// Used by every module of the block; depends on nothing else.
package nfopll_pkg;

    localparam int DW           = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int OPW          = DW + 1;
    localparam int PW           = 2 * OPW;
    localparam int DIV_SHIFT    = 20;
    localparam int DIV_BITS     = DW + DIV_SHIFT;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;

    localparam logic [OPW-1:0] LPF_COEF  = 33'd42950;
    localparam logic [OPW-1:0] INV_PI    = 33'd1367130551;
    localparam logic [CW-1:0]  CORDIC_K  = 34'd652032874;
    localparam logic [DW-1:0]  SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [DW-1:0]  SAT_MIN   = 32'h8000_0000;

    typedef enum logic [2:0] {
        CFG_IND,
        CFG_RES,
        CFG_FLUX,
        CFG_GAM,
        CFG_TS,
        CFG_KP,
        CFG_KI
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_LIA, OP_LIB, OP_F2, OP_SQA, OP_SQB, OP_PA, OP_PB, OP_DA, OP_DB,
        OP_RA, OP_RB, OP_TA, OP_TB,
        OP_ERR1, OP_ERR2, OP_INT, OP_KP, OP_KI, OP_LPF, OP_RAD, OP_INC_LO, OP_INC_HI
    } mul_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_START,
        S_SOLVE,
        S_MUL2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [DW-1:0] volt_alpha;
        logic signed [DW-1:0] volt_beta;
        logic signed [DW-1:0] curr_alpha;
        logic signed [DW-1:0] curr_beta;
    } in_beat_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle_est;
        logic signed [DW-1:0]         speed_est;
        logic signed [DW-1:0]         speed_filtered;
        logic signed [DW-1:0]         phase_error;
        logic signed [DW-1:0]         cos_est;
        logic signed [DW-1:0]         sin_est;
    } out_beat_t;

    typedef struct packed {
        logic    load;
        logic    issue;
        mul_op_t op;
        logic    start;
        logic    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic solve_done;
    } ctl_status_t;

    function automatic logic [DW-1:0] sat33(input logic [DW:0] v);
        logic [DW-1:0] r;
        if (v[DW] != v[DW-1]) begin
            r = v[DW] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] add_sat(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return sat33({a[DW-1], a} + {b[DW-1], b});
    endfunction

    function automatic logic [DW-1:0] sub_sat(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return sat33({a[DW-1], a} - {b[DW-1], b});
    endfunction

    function automatic logic [5:0] op_shift(input mul_op_t op);
        logic [5:0] s;
        case (op)
            OP_LIA, OP_LIB, OP_TA, OP_TB:           s = 6'd20;
            OP_F2:                                  s = 6'd36;
            OP_SQA, OP_SQB, OP_PA, OP_PB,
            OP_DA, OP_DB:                           s = 6'd28;
            OP_INT, OP_KI:                          s = 6'd24;
            OP_LPF:                                 s = 6'd32;
            default:                                s = 6'd16;
        endcase
        return s;
    endfunction

    function automatic logic [CW-1:0] atan_q30(input logic [4:0] i);
        logic [CW-1:0] r;
        case (i)
            5'd0:    r = 34'd536870912;
            5'd1:    r = 34'd316933406;
            5'd2:    r = 34'd167458907;
            5'd3:    r = 34'd85004756;
            5'd4:    r = 34'd42667331;
            5'd5:    r = 34'd21354465;
            5'd6:    r = 34'd10679838;
            5'd7:    r = 34'd5340245;
            5'd8:    r = 34'd2670163;
            5'd9:    r = 34'd1335087;
            5'd10:   r = 34'd667544;
            5'd11:   r = 34'd333772;
            5'd12:   r = 34'd166886;
            5'd13:   r = 34'd83443;
            5'd14:   r = 34'd41722;
            5'd15:   r = 34'd20861;
            5'd16:   r = 34'd10430;
            5'd17:   r = 34'd5215;
            5'd18:   r = 34'd2608;
            5'd19:   r = 34'd1304;
            5'd20:   r = 34'd652;
            5'd21:   r = 34'd326;
            5'd22:   r = 34'd163;
            5'd23:   r = 34'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/nfopll_div.sv -----
// Bit-serial restoring divider: signed numerator scaled up, unsigned flux divisor.
// Depends on nfopll_pkg.
module nfopll_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nfopll_pkg::DW-1:0] num,
    input  logic [nfopll_pkg::DW-1:0] den,
    output logic [nfopll_pkg::DW-1:0] quo,
    output logic                      done
);

    localparam int DW = nfopll_pkg::DW;
    localparam int NB = nfopll_pkg::DIV_BITS;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic [NB-1:0] nq_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] mag;
    logic          ovf;

    assign mag   = num[DW-1] ? (~num + 1'b1) : num;
    assign trial = {rem_reg, nq_reg[NB-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(NB - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= {mag, {nfopll_pkg::DIV_SHIFT{1'b0}}};
            rem_reg <= '0;
            den_reg <= (den == '0) ? DW'(1) : den;
            neg_reg <= num[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            nq_reg  <= {nq_reg[NB-2:0], fits};
        end
    end

    assign ovf  = |nq_reg[NB-1:DW-1];
    assign quo  = ovf ? (neg_reg ? nfopll_pkg::SAT_MIN : nfopll_pkg::SAT_MAX)
                      : (neg_reg ? (~nq_reg[DW-1:0] + 1'b1) : nq_reg[DW-1:0]);
    assign done = done_reg;

endmodule

// ----- hdl/nfopll_cordic.sv -----
// Iterative rotation CORDIC giving the cosine and sine of the PLL angle in Q16.
// Depends on nfopll_pkg.
module nfopll_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [nfopll_pkg::ANGLE_BITS-1:0] angle,
    output logic [nfopll_pkg::DW-1:0]         cos_q,
    output logic [nfopll_pkg::DW-1:0]         sin_q,
    output logic                              done
);

    localparam int CW = nfopll_pkg::CW;
    localparam int AB = nfopll_pkg::ANGLE_BITS;

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           i_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic                 fold_reg;
    logic                 fold;
    logic [31:0]          phase;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] sy;

    assign fold  = angle[AB-1] ^ angle[AB-2];
    assign phase = {angle[AB-1] ^ fold, angle[AB-2:0], {(32 - AB){1'b0}}};
    assign dx    = y_reg >>> i_reg;
    assign dy    = x_reg >>> i_reg;
    assign at    = $signed(nfopll_pkg::atan_q30(i_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + 5'd1;
            if (i_reg == 5'(nfopll_pkg::CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed(nfopll_pkg::CORDIC_K);
            y_reg    <= '0;
            z_reg    <= CW'($signed(phase));
            fold_reg <= fold;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cx    = fold_reg ? -(x_reg >>> 14) : (x_reg >>> 14);
    assign sy    = fold_reg ? -(y_reg >>> 14) : (y_reg >>> 14);
    assign cos_q = cx[nfopll_pkg::DW-1:0];
    assign sin_q = sy[nfopll_pkg::DW-1:0];
    assign done  = done_reg;

endmodule

// ----- hdl/nfopll_ctrl.sv -----
// Sequencing state machine: walks the multiply steps, starts the divide and CORDIC phase.
// Depends on nfopll_pkg.
module nfopll_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  nfopll_pkg::ctl_status_t status,
    output nfopll_pkg::ctl_cmd_t    cmd
);

    nfopll_pkg::state_t  state_reg;
    nfopll_pkg::state_t  state_next;
    nfopll_pkg::mul_op_t op_reg;
    nfopll_pkg::mul_op_t op_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfopll_pkg::S_IDLE;
            op_reg        <= nfopll_pkg::OP_LIA;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            nfopll_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = nfopll_pkg::S_MUL1;
                    op_next    = nfopll_pkg::OP_LIA;
                    phase_next = '0;
                end
            end
            nfopll_pkg::S_MUL1, nfopll_pkg::S_MUL2:
            begin
                cmd.issue = (phase_reg == 2'd0);
                if (phase_reg == 2'd2)
                begin
                    phase_next = '0;
                    if (op_reg == nfopll_pkg::OP_TB)
                    begin
                        state_next = nfopll_pkg::S_START;
                    end
                    else if (op_reg == nfopll_pkg::OP_INC_HI)
                    begin
                        state_next = nfopll_pkg::S_DONE;
                    end
                    else
                    begin
                        op_next = nfopll_pkg::mul_op_t'(5'(op_reg) + 5'd1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            nfopll_pkg::S_START:
            begin
                cmd.start  = 1'b1;
                state_next = nfopll_pkg::S_SOLVE;
            end
            nfopll_pkg::S_SOLVE:
            begin
                if (status.solve_done)
                begin
                    state_next = nfopll_pkg::S_MUL2;
                    op_next    = nfopll_pkg::OP_ERR1;
                    phase_next = '0;
                end
            end
            nfopll_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = nfopll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfopll_pkg::S_IDLE;
            end
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/nfopll_dp.sv -----
// Datapath: configuration registers, observer and PLL state, shared multiplier,
// flux dividers and CORDIC. Depends on nfopll_pkg, nfopll_div and nfopll_cordic.
module nfopll_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nfopll_pkg::ctl_cmd_t      cmd,
    output nfopll_pkg::ctl_status_t   status,
    input  nfopll_pkg::in_beat_t      in_data,
    output nfopll_pkg::out_beat_t     out_data,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [nfopll_pkg::DW-1:0] cfg_data
);

    localparam int DW  = nfopll_pkg::DW;
    localparam int OPW = nfopll_pkg::OPW;
    localparam int PW  = nfopll_pkg::PW;
    localparam int AB  = nfopll_pkg::ANGLE_BITS;

    logic [DW-1:0] ind_reg, res_reg, flux_reg, gam_reg, ts_reg, kp_reg, ki_reg;
    logic [DW-1:0] fa_reg, fb_reg, integ_reg, lpf_reg;
    logic [AB-1:0] angle_reg;
    logic [DW-1:0] ua_reg, ub_reg, ia_reg, ib_reg;
    logic [DW-1:0] lia_reg, lib_reg, xa_reg, xb_reg, f2_reg, sq_reg, eta_reg;
    logic [DW-1:0] pa_reg, pb_reg, da_reg, db_reg, numa_reg, numb_reg;
    logic [DW-1:0] e1_reg, err_reg, kpt_reg, spd_reg;
    logic [46:0]   rad_reg;
    logic          rad_neg_reg;
    logic [31:0]   pl_reg;
    nfopll_pkg::out_beat_t out_reg;

    logic                v_s1_reg, v_s2_reg;
    nfopll_pkg::mul_op_t op_s1_reg, op_s2_reg;
    logic [OPW-1:0]      am_reg, bm_reg;
    logic                neg_s1_reg, neg_s2_reg;
    logic [PW-1:0]       prod_reg;

    logic [OPW-1:0] a_op, b_op, am, bm;
    logic [OPW-1:0] lpf_diff;
    logic [PW-1:0]  pm;
    logic [DW-1:0]  res;
    logic [48:0]    inc_sum;
    logic [AB-1:0]  inc;
    logic [DW-1:0]  fa_new, fb_new;
    logic [DW-1:0]  cs, sn, ch, sh;
    logic           dva, dvb, dvc;

    assign lpf_diff = {spd_reg[DW-1], spd_reg} - {lpf_reg[DW-1], lpf_reg};

    always_comb
    begin
        case (cmd.op)
            nfopll_pkg::OP_LIA:    begin a_op = {ia_reg[DW-1], ia_reg}; b_op = {1'b0, ind_reg}; end
            nfopll_pkg::OP_LIB:    begin a_op = {ib_reg[DW-1], ib_reg}; b_op = {1'b0, ind_reg}; end
            nfopll_pkg::OP_F2:     begin a_op = {1'b0, flux_reg};       b_op = {1'b0, flux_reg}; end
            nfopll_pkg::OP_SQA:    begin a_op = {xa_reg[DW-1], xa_reg}; b_op = {xa_reg[DW-1], xa_reg}; end
            nfopll_pkg::OP_SQB:    begin a_op = {xb_reg[DW-1], xb_reg}; b_op = {xb_reg[DW-1], xb_reg}; end
            nfopll_pkg::OP_PA:     begin a_op = {xa_reg[DW-1], xa_reg}; b_op = {eta_reg[DW-1], eta_reg}; end
            nfopll_pkg::OP_PB:     begin a_op = {xb_reg[DW-1], xb_reg}; b_op = {eta_reg[DW-1], eta_reg}; end
            nfopll_pkg::OP_DA:     begin a_op = {pa_reg[DW-1], pa_reg}; b_op = {1'b0, gam_reg}; end
            nfopll_pkg::OP_DB:     begin a_op = {pb_reg[DW-1], pb_reg}; b_op = {1'b0, gam_reg}; end
            nfopll_pkg::OP_RA:     begin a_op = {ia_reg[DW-1], ia_reg}; b_op = {1'b0, res_reg}; end
            nfopll_pkg::OP_RB:     begin a_op = {ib_reg[DW-1], ib_reg}; b_op = {1'b0, res_reg}; end
            nfopll_pkg::OP_TA:     begin a_op = {da_reg[DW-1], da_reg}; b_op = {1'b0, ts_reg}; end
            nfopll_pkg::OP_TB:     begin a_op = {db_reg[DW-1], db_reg}; b_op = {1'b0, ts_reg}; end
            nfopll_pkg::OP_ERR1:   begin a_op = {sn[DW-1], sn};         b_op = {ch[DW-1], ch}; end
            nfopll_pkg::OP_ERR2:   begin a_op = {cs[DW-1], cs};         b_op = {sh[DW-1], sh}; end
            nfopll_pkg::OP_INT:    begin a_op = {err_reg[DW-1], err_reg}; b_op = {1'b0, ts_reg}; end
            nfopll_pkg::OP_KP:     begin a_op = {err_reg[DW-1], err_reg}; b_op = {1'b0, kp_reg}; end
            nfopll_pkg::OP_KI:     begin a_op = {integ_reg[DW-1], integ_reg}; b_op = {1'b0, ki_reg}; end
            nfopll_pkg::OP_LPF:    begin a_op = lpf_diff;               b_op = nfopll_pkg::LPF_COEF; end
            nfopll_pkg::OP_RAD:    begin a_op = {spd_reg[DW-1], spd_reg}; b_op = {1'b0, ts_reg}; end
            nfopll_pkg::OP_INC_LO: begin a_op = {1'b0, rad_reg[31:0]};  b_op = nfopll_pkg::INV_PI; end
            nfopll_pkg::OP_INC_HI: begin a_op = {18'b0, rad_reg[46:32]}; b_op = nfopll_pkg::INV_PI; end
            default:               begin a_op = '0;                     b_op = '0; end
        endcase
        am = a_op[OPW-1] ? (~a_op + 1'b1) : a_op;
        bm = b_op[OPW-1] ? (~b_op + 1'b1) : b_op;
    end

    always_comb
    begin
        pm  = prod_reg >> nfopll_pkg::op_shift(op_s2_reg);
        if (|pm[PW-1:DW-1])
        begin
            res = neg_s2_reg ? nfopll_pkg::SAT_MIN : nfopll_pkg::SAT_MAX;
        end
        else
        begin
            res = neg_s2_reg ? (~pm[DW-1:0] + 1'b1) : pm[DW-1:0];
        end
        inc_sum = {17'b0, pl_reg} + {1'b0, prod_reg[47:0]};
        inc     = rad_neg_reg ? (~inc_sum[32:17] + 1'b1) : inc_sum[32:17];
        fa_new  = nfopll_pkg::add_sat(fa_reg, res);
        fb_new  = nfopll_pkg::add_sat(fb_reg, res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ind_reg   <= '0;
            res_reg   <= '0;
            flux_reg  <= DW'(1);
            gam_reg   <= '0;
            ts_reg    <= '0;
            kp_reg    <= '0;
            ki_reg    <= '0;
            fa_reg    <= '0;
            fb_reg    <= '0;
            integ_reg <= '0;
            lpf_reg   <= '0;
            angle_reg <= '0;
            v_s1_reg  <= 1'b0;
            v_s2_reg  <= 1'b0;
        end
        else
        begin
            v_s1_reg <= cmd.issue;
            v_s2_reg <= v_s1_reg;
            if (cfg_we)
            begin
                case (cfg_index)
                    nfopll_pkg::CFG_IND:  ind_reg  <= cfg_data;
                    nfopll_pkg::CFG_RES:  res_reg  <= cfg_data;
                    nfopll_pkg::CFG_FLUX: flux_reg <= cfg_data;
                    nfopll_pkg::CFG_GAM:  gam_reg  <= cfg_data;
                    nfopll_pkg::CFG_TS:   ts_reg   <= cfg_data;
                    nfopll_pkg::CFG_KP:   kp_reg   <= cfg_data;
                    nfopll_pkg::CFG_KI:   ki_reg   <= cfg_data;
                    default:              ;
                endcase
            end
            if (v_s2_reg)
            begin
                case (op_s2_reg)
                    nfopll_pkg::OP_TA:     fa_reg    <= fa_new;
                    nfopll_pkg::OP_TB:     fb_reg    <= fb_new;
                    nfopll_pkg::OP_INT:    integ_reg <= nfopll_pkg::add_sat(integ_reg, res);
                    nfopll_pkg::OP_LPF:    lpf_reg   <= nfopll_pkg::add_sat(lpf_reg, res);
                    nfopll_pkg::OP_INC_HI: angle_reg <= angle_reg + inc;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ua_reg <= in_data.volt_alpha;
            ub_reg <= in_data.volt_beta;
            ia_reg <= in_data.curr_alpha;
            ib_reg <= in_data.curr_beta;
        end
        if (cmd.issue)
        begin
            am_reg     <= am;
            bm_reg     <= bm;
            neg_s1_reg <= a_op[OPW-1] ^ b_op[OPW-1];
            op_s1_reg  <= cmd.op;
        end
        prod_reg   <= am_reg * bm_reg;
        neg_s2_reg <= neg_s1_reg;
        op_s2_reg  <= op_s1_reg;
        if (v_s2_reg)
        begin
            case (op_s2_reg)
                nfopll_pkg::OP_LIA:
                begin
                    lia_reg <= res;
                    xa_reg  <= nfopll_pkg::sub_sat(fa_reg, res);
                end
                nfopll_pkg::OP_LIB:
                begin
                    lib_reg <= res;
                    xb_reg  <= nfopll_pkg::sub_sat(fb_reg, res);
                end
                nfopll_pkg::OP_F2:   f2_reg <= res;
                nfopll_pkg::OP_SQA:  sq_reg <= res;
                nfopll_pkg::OP_SQB:
                    eta_reg <= nfopll_pkg::sub_sat(f2_reg, nfopll_pkg::add_sat(sq_reg, res));
                nfopll_pkg::OP_PA:   pa_reg <= res;
                nfopll_pkg::OP_PB:   pb_reg <= res;
                nfopll_pkg::OP_DA:   da_reg <= res;
                nfopll_pkg::OP_DB:   db_reg <= res;
                nfopll_pkg::OP_RA:
                    da_reg <= nfopll_pkg::add_sat(nfopll_pkg::sub_sat(da_reg, res), ua_reg);
                nfopll_pkg::OP_RB:
                    db_reg <= nfopll_pkg::add_sat(nfopll_pkg::sub_sat(db_reg, res), ub_reg);
                nfopll_pkg::OP_TA:   numa_reg <= nfopll_pkg::sub_sat(fa_new, lia_reg);
                nfopll_pkg::OP_TB:   numb_reg <= nfopll_pkg::sub_sat(fb_new, lib_reg);
                nfopll_pkg::OP_ERR1: e1_reg <= res;
                nfopll_pkg::OP_ERR2: err_reg <= nfopll_pkg::sub_sat(e1_reg, res);
                nfopll_pkg::OP_KP:   kpt_reg <= res;
                nfopll_pkg::OP_KI:   spd_reg <= nfopll_pkg::add_sat(kpt_reg, res);
                nfopll_pkg::OP_RAD:
                begin
                    rad_reg     <= prod_reg[62:16];
                    rad_neg_reg <= neg_s2_reg;
                end
                nfopll_pkg::OP_INC_LO: pl_reg <= prod_reg[63:32];
                default:               ;
            endcase
        end
        if (cmd.emit)
        begin
            out_reg.angle_est      <= angle_reg;
            out_reg.speed_est      <= spd_reg;
            out_reg.speed_filtered <= lpf_reg;
            out_reg.phase_error    <= err_reg;
            out_reg.cos_est        <= cs;
            out_reg.sin_est        <= sn;
        end
    end

    nfopll_div u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .num   (numa_reg),
        .den   (flux_reg),
        .quo   (cs),
        .done  (dva)
    );

    nfopll_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .num   (numb_reg),
        .den   (flux_reg),
        .quo   (sn),
        .done  (dvb)
    );

    nfopll_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .angle (angle_reg),
        .cos_q (ch),
        .sin_q (sh),
        .done  (dvc)
    );

    assign status.solve_done = dva & dvb & dvc;
    assign out_data          = out_reg;

endmodule

// ----- hdl/nonlinear_flux_observer_pll.sv -----
// Top level of the nonlinear flux observer with PLL angle tracking.
// Depends on nfopll_pkg, nfopll_ctrl and nfopll_dp.
//
// After an input beat is accepted, the 22 multiply steps go through one shared two-stage
// multiplier, each step waiting for the product of the one before. A further state then
// starts the solve, which waits for the 52-step bit-serial divide of both flux axes that
// runs alongside the 24-step CORDIC. A last state loads the output register. A new beat is
// taken in the cycle after the result is loaded, even if that result has not yet been
// collected. A result that is not collected holds the next beat in its final state until
// the output register is free. Configuration writes go straight into their registers.
module nonlinear_flux_observer_pll (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  nfopll_pkg::in_beat_t      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output nfopll_pkg::out_beat_t     out_data,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [nfopll_pkg::DW-1:0] cfg_data
);

    nfopll_pkg::ctl_cmd_t    cmd;
    nfopll_pkg::ctl_status_t status;

    nfopll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nfopll_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- hdl/nfopll_chk.sv -----
// Port-level checks for the flux observer with PLL, bound to the top level.
// Depends on nfopll_pkg.
module nfopll_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input nfopll_pkg::out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result beat dropped before it was taken.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("Result beat changed while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input taken again while a beat is being worked on.");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("Result appeared in the cycle after an input beat.");

endmodule

bind nonlinear_flux_observer_pll nfopll_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
